// ===== src/sacl_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sacl_pkg: shared types and codes for the set-associative LRU tag array
// Request/response payloads, status codes and configuration register indexes.
// ---------------------------------------------------------------------------
package sacl_pkg;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT_LOG2  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE_LOG2 = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_READ_HIT  = 2'd0;
  localparam logic [1:0] STATUS_READ_MISS = 2'd1;
  localparam logic [1:0] STATUS_WRITE     = 2'd2;

  // Access commands
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef struct packed {
    logic        command;
    logic [15:0] address;
    logic [15:0] pc_tag;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  set_index;
    logic [15:0] pc_echo;
  } rsp_t;

endpackage
`default_nettype wire

// ===== src/sacl_ram.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sacl_ram: generic single-write, single-read RAM
// One write port and one read port; read data registered.
// ---------------------------------------------------------------------------
module sacl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                        wdata_i,
  input  wire logic                                    re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== src/sacl_lru_update.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sacl_lru_update: tag match and true-LRU update of one cache set
// Finds the hitting way or the least recent victim and returns the new row.
// ---------------------------------------------------------------------------
module sacl_lru_update #(
  parameter int unsigned MAX_WAYS = 16,
  parameter int unsigned TAG_W    = 16,
  localparam int unsigned RANK_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
  localparam int unsigned NW_W    = $clog2(MAX_WAYS + 1),
  localparam int unsigned ENTRY_W = 1 + TAG_W + RANK_W,
  localparam int unsigned ROW_W   = MAX_WAYS * ENTRY_W
) (
  input  wire logic [ROW_W-1:0] row_i,
  input  wire logic [TAG_W-1:0] tag_i,
  input  wire logic [NW_W-1:0]  nw_i,
  output logic                  hit_o,
  output logic      [ROW_W-1:0] row_o
);

  // entry layout: {valid, tag, rank}
  logic              valid   [MAX_WAYS];
  logic [TAG_W-1:0]  tags    [MAX_WAYS];
  logic [RANK_W-1:0] rank    [MAX_WAYS];
  logic [RANK_W-1:0] hit_way;
  logic [RANK_W-1:0] vic_way;
  logic [RANK_W-1:0] sel_way;
  logic [RANK_W-1:0] old_rank;
  logic              hit;
  logic              vic_found;

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      {valid[w], tags[w], rank[w]} = row_i[w*ENTRY_W +: ENTRY_W];
    end
  end

  always_comb begin
    hit       = 1'b0;
    hit_way   = '0;
    vic_found = 1'b0;
    vic_way   = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (!hit && (NW_W'(w) < nw_i) && valid[w] && (tags[w] == tag_i)) begin
        hit     = 1'b1;
        hit_way = RANK_W'(w);
      end
      if (!vic_found && (NW_W'(w) < nw_i) && (rank[w] == '0)) begin
        vic_found = 1'b1;
        vic_way   = RANK_W'(w);
      end
    end
  end

  assign sel_way  = hit ? hit_way : vic_way;
  assign old_rank = rank[sel_way];
  assign hit_o    = hit;

  // age every younger way by one, move the chosen way to most recent
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (RANK_W'(w) == sel_way) begin
        row_o[w*ENTRY_W +: ENTRY_W] = {1'b1, tag_i, RANK_W'(nw_i - 1'b1)};
      end else if ((NW_W'(w) < nw_i) && (rank[w] > old_rank)) begin
        row_o[w*ENTRY_W +: ENTRY_W] = {valid[w], tags[w], rank[w] - 1'b1};
      end else begin
        row_o[w*ENTRY_W +: ENTRY_W] = {valid[w], tags[w], rank[w]};
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/set_assoc_lru_cache_tags.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// set_assoc_lru_cache_tags: set-associative cache tag array, true LRU
// An accepted access reads its set row from the tag RAM into the read register;
//   in the lookup state the row is compared and written back, and the result
//   and its strobe are registered. A new access is not taken until the
//   read-modify-write of the set row is done; busy is high during the write-back cycle.
// Reset and any known configuration write clear the per-set valid bits at
//   once; no clearing pass. Results cannot be stalled.
// ---------------------------------------------------------------------------
module set_assoc_lru_cache_tags
  import sacl_pkg::*;
#(
  parameter int unsigned MAX_SETS  = 256,
  parameter int unsigned MAX_WAYS  = 16,
  parameter int unsigned ADDR_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire req_t                  req_i,
  output logic                       rsp_valid_o,
  output rsp_t                       rsp_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned AW      = (ADDR_BITS < 16) ? ADDR_BITS : 16;
  localparam int unsigned SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int unsigned XW      = (AW > SET_W) ? AW : SET_W;
  localparam int unsigned RL_MAX  = $clog2(MAX_SETS + 1) - 1;
  localparam int unsigned RANK_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned NW_W    = $clog2(MAX_WAYS + 1);
  localparam int unsigned ENTRY_W = 1 + AW + RANK_W;
  localparam int unsigned ROW_W   = MAX_WAYS * ENTRY_W;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_LOOKUP = 2'b10
  } state_e;

  state_e state_q, state_d;

  logic [4:0] ways_q;
  logic [3:0] rows_q;
  logic [2:0] bsl_q;

  logic [MAX_SETS-1:0] rowv_q;

  logic             pend_cmd_q;
  logic [15:0]      pend_pc_q;
  logic [SET_W-1:0] pend_set_q;
  logic [7:0]       pend_set8_q;
  logic [AW-1:0]    pend_tag_q;
  logic             pend_rowv_q;

  logic rsp_valid_q;
  rsp_t rsp_q;

  logic             accept;
  logic             cfg_we;
  logic             cfg_known;
  logic [3:0]       rl;
  logic [XW-1:0]    block;
  logic [XW-1:0]    set_x;
  logic [AW-1:0]    tag;
  logic [NW_W-1:0]  nw;
  logic [ROW_W-1:0] ram_rdata;
  logic [ROW_W-1:0] row_cur;
  logic [ROW_W-1:0] row_new;
  logic             hit;

  assign busy        = (state_q == ST_LOOKUP);
  assign accept      = start && !busy;
  // hold off configuration while an access is offered or in flight
  assign cfg_ready_o = (state_q == ST_IDLE) && !start;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign cfg_known   = (cfg_index_i == CFG_WAYS_IN_USE) ||
                       (cfg_index_i == CFG_ROW_COUNT_LOG2) ||
                       (cfg_index_i == CFG_BLOCK_SIZE_LOG2);

  // split the address into set and tag
  assign rl    = (rows_q > 4'(RL_MAX)) ? 4'(RL_MAX) : rows_q;
  assign block = XW'(req_i.address[AW-1:0]) >> bsl_q;
  assign set_x = block & ~({XW{1'b1}} << rl);
  assign tag   = AW'(block >> rl);

  always_comb begin
    if (ways_q == 5'd0) begin
      nw = NW_W'(1);
    end else if (ways_q > 5'(MAX_WAYS)) begin
      nw = NW_W'(MAX_WAYS);
    end else begin
      nw = NW_W'(ways_q);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (accept) state_d = ST_LOOKUP;
      ST_LOOKUP: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ways_q      <= 5'd1;
      rows_q      <= 4'd0;
      bsl_q       <= 3'd0;
      rowv_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= (state_q == ST_LOOKUP);
      if (cfg_we) begin
        unique case (cfg_index_i)
          CFG_WAYS_IN_USE:     ways_q <= cfg_data_i[4:0];
          CFG_ROW_COUNT_LOG2:  rows_q <= cfg_data_i[3:0];
          CFG_BLOCK_SIZE_LOG2: bsl_q  <= cfg_data_i[2:0];
          default: ;
        endcase
      end
      // flush on any known register write; mark a set live on write-back
      if (cfg_we && cfg_known) begin
        rowv_q <= '0;
      end else if (state_q == ST_LOOKUP) begin
        rowv_q[pend_set_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_cmd_q  <= req_i.command;
      pend_pc_q   <= req_i.pc_tag;
      pend_set_q  <= set_x[SET_W-1:0];
      pend_set8_q <= set_x[7:0];
      pend_tag_q  <= tag;
      pend_rowv_q <= rowv_q[set_x[SET_W-1:0]];
    end
    if (state_q == ST_LOOKUP) begin
      if (pend_cmd_q == CMD_WRITE) begin
        rsp_q.status <= STATUS_WRITE;
      end else begin
        rsp_q.status <= hit ? STATUS_READ_HIT : STATUS_READ_MISS;
      end
      rsp_q.set_index <= pend_set8_q;
      rsp_q.pc_echo   <= pend_pc_q;
    end
  end

  // a set never written since flush reads as its reset contents
  always_comb begin
    if (pend_rowv_q) begin
      row_cur = ram_rdata;
    end else begin
      for (int w = 0; w < MAX_WAYS; w++) begin
        row_cur[w*ENTRY_W +: ENTRY_W] = {1'b0, {AW{1'b0}}, RANK_W'(w)};
      end
    end
  end

  sacl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_SETS)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_LOOKUP),
    .waddr_i (pend_set_q),
    .wdata_i (row_new),
    .re_i    (accept),
    .raddr_i (set_x[SET_W-1:0]),
    .rdata_o (ram_rdata)
  );

  sacl_lru_update #(
    .MAX_WAYS (MAX_WAYS),
    .TAG_W    (AW)
  ) u_lru_update (
    .row_i (row_cur),
    .tag_i (pend_tag_q),
    .nw_i  (nw),
    .hit_o (hit),
    .row_o (row_new)
  );

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule
`default_nettype wire

// ===== verif/set_assoc_lru_cache_tags_test.sv =====
// ---------------------------------------------------------------------------
// set_assoc_lru_cache_tags_test: self-checking bench for the LRU tag array
// Drives read and write accesses through several cache geometries, keeps a
// tag array of its own with true LRU ranks, and checks every response beat
// field by field against the expected status, set index and echoed pc.
// ---------------------------------------------------------------------------
module set_assoc_lru_cache_tags_test;
  import sacl_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam int unsigned STALL_LIMIT = 500;
  localparam int unsigned PHASES = 12;
  localparam int unsigned PHASE_ITEMS = 150;

  // Tag array predictor and store of expected response beats
  class lru_tag_model;
    localparam int unsigned SETS = 256;
    localparam int unsigned WAYS = 16;
    localparam int unsigned SETS_LOG2 = 8;

    logic [4:0] ways_cfg;
    logic [3:0] rows_cfg;
    logic [2:0] block_cfg;
    bit          line_valid [SETS][WAYS];
    logic [15:0] line_tag   [SETS][WAYS];
    logic [3:0]  line_rank  [SETS][WAYS];
    rsp_t        expected_rsp_q [$];
    int unsigned errors;

    function new();
      ways_cfg  = 5'd1;
      rows_cfg  = 4'd0;
      block_cfg = 3'd0;
      errors    = 0;
      flush();
    endfunction

    function void flush();
      int unsigned s, w;
      for (s = 0; s < SETS; s++) begin
        for (w = 0; w < WAYS; w++) begin
          line_valid[s][w] = 1'b0;
          line_tag[s][w]   = '0;
          line_rank[s][w]  = 4'(w);
        end
      end
    endfunction

    function int unsigned ways_eff();
      if (ways_cfg == 0) return 1;
      if (ways_cfg > WAYS) return WAYS;
      return 32'(ways_cfg);
    endfunction

    function int unsigned rows_eff();
      return (rows_cfg > SETS_LOG2) ? SETS_LOG2 : 32'(rows_cfg);
    endfunction

    function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_WAYS_IN_USE:     ways_cfg  = data;
        CFG_ROW_COUNT_LOG2:  rows_cfg  = data[3:0];
        CFG_BLOCK_SIZE_LOG2: block_cfg = data[2:0];
        default: return;
      endcase
      flush();
    endfunction

    // Make way w the most recent of the nw ways in set s
    function void promote(int unsigned s, int unsigned w, int unsigned nw);
      logic [3:0] old;
      int unsigned k;
      old = line_rank[s][w];
      for (k = 0; k < nw; k++) begin
        if (line_rank[s][k] > old) line_rank[s][k]--;
      end
      line_rank[s][w] = 4'(nw - 1);
    endfunction

    function void note_access(req_t r);
      int unsigned nw, rl, s, w, way;
      logic [15:0] blk, tg;
      bit hit;
      rsp_t e;
      nw  = ways_eff();
      rl  = rows_eff();
      blk = r.address >> block_cfg;
      s   = int'(blk) & ((1 << rl) - 1);
      tg  = blk >> rl;
      hit = 1'b0;
      way = 0;
      for (w = 0; w < nw; w++) begin
        if (!hit && line_valid[s][w] && line_tag[s][w] == tg) begin
          hit = 1'b1;
          way = w;
        end
      end
      if (!hit) begin
        // victim is the way holding rank zero, lowest index first
        for (w = nw; w > 0; w--) begin
          if (line_rank[s][w-1] == 0) way = w - 1;
        end
        line_valid[s][way] = 1'b1;
        line_tag[s][way]   = tg;
      end
      promote(s, way, nw);
      if (r.command == CMD_WRITE) e.status = STATUS_WRITE;
      else e.status = hit ? STATUS_READ_HIT : STATUS_READ_MISS;
      e.set_index = 8'(s);
      e.pc_echo   = r.pc_tag;
      expected_rsp_q = {expected_rsp_q, e};
    endfunction

    function void flag(string what, int unsigned exp_v, int unsigned act_v);
      errors++;
      if (errors <= 40)
        $display("%0t: %s, expected %0h, actual %0h", $time, what, exp_v, act_v);
      else if (errors == 41)
        $display("%0t: further mismatches not shown", $time);
    endfunction

    function void check_result(rsp_t got);
      rsp_t e;
      if (expected_rsp_q.size() == 0) begin
        flag("response beat with nothing pending", 0, 32'(got));
        return;
      end
      e = expected_rsp_q[0];
      expected_rsp_q.delete(0);
      if (got.status !== e.status)
        flag("status mismatch", 32'(e.status), 32'(got.status));
      if (got.set_index !== e.set_index)
        flag("set_index mismatch", 32'(e.set_index), 32'(got.set_index));
      if (got.pc_echo !== e.pc_echo)
        flag("pc_echo mismatch", 32'(e.pc_echo), 32'(got.pc_echo));
    endfunction

    function void close_out();
      while (expected_rsp_q.size() != 0) begin
        flag("response never seen, pc", 32'(expected_rsp_q[0].pc_echo), 0);
        expected_rsp_q.delete(0);
      end
    endfunction
  endclass

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start       = 1'b0;
  logic                  busy;
  req_t                  req_i       = '0;
  logic                  rsp_valid_o;
  rsp_t                  rsp_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  lru_tag_model tags;
  int unsigned  stall_cycles = 0;

  set_assoc_lru_cache_tags dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Check response beats before noting the access accepted on the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_valid_o) tags.check_result(rsp_o);
      if (start && !busy) tags.note_access(req_i);
      if (cfg_valid_i && cfg_ready_o) tags.apply_register(cfg_index_i, cfg_data_i);
      stall_cycles <= (rsp_valid_o || (start && !busy) || (cfg_valid_i && cfg_ready_o))
                      ? 0 : stall_cycles + 1;
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_access(input req_t r);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic hold_off(input int unsigned cycles);
    if (cycles != 0) begin
      start <= 1'b0;
      req_i <= '{command: 1'($urandom), address: 16'($urandom), pc_tag: 16'($urandom)};
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drop start and wait until every pending beat is back
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (tags.expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mostly a small working set of blocks in a few sets, so hits and evictions occur
  function automatic logic [15:0] pick_address(int unsigned nw, int unsigned rl,
                                               int unsigned bs, int unsigned tag_base);
    int unsigned tag_v, set_v, blk;
    if ($urandom_range(0, 4) == 0) return 16'($urandom);
    tag_v = tag_base + $urandom_range(0, nw + 2);
    set_v = $urandom_range(0, 3) & ((1 << rl) - 1);
    blk   = (tag_v << rl) | set_v;
    return 16'((blk << bs) | $urandom_range(0, (1 << bs) - 1));
  endfunction

  initial begin
    int unsigned phase, n, tag_base;
    logic [4:0] ways_v, rows_v, blk_v;
    logic [2:0] write_mask;
    bit no_gaps;
    tags = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset geometry: one way, one set, one-cell blocks
    send_access('{CMD_READ,  16'h0000, 16'h0000});
    send_access('{CMD_READ,  16'h0000, 16'hFFFF});
    send_access('{CMD_WRITE, 16'hFFFF, 16'h1234});
    hold_off(1);
    send_access('{CMD_READ,  16'hFFFF, 16'hA5A5});
    send_access('{CMD_READ,  16'h0000, 16'h5A5A});
    settle();

    // Two ways, two sets, two-cell blocks: walk the LRU order of set zero
    set_register(CFG_WAYS_IN_USE, 5'd2);
    set_register(CFG_ROW_COUNT_LOG2, 5'd1);
    set_register(CFG_BLOCK_SIZE_LOG2, 5'd1);
    send_access('{CMD_READ,  16'h0000, 16'h0001});
    send_access('{CMD_READ,  16'h0004, 16'h0002});
    send_access('{CMD_READ,  16'h0000, 16'h0003});
    send_access('{CMD_WRITE, 16'h0008, 16'h0004});
    send_access('{CMD_READ,  16'h0004, 16'h0005});
    send_access('{CMD_READ,  16'h0000, 16'h0006});
    send_access('{CMD_READ,  16'h0002, 16'h0007});
    send_access('{CMD_READ,  16'h0003, 16'h0008});
    settle();

    // Unknown register index: no flush, so set one still hits
    set_register(CFG_UNUSED_IDX, 5'h1F);
    send_access('{CMD_READ, 16'h0002, 16'h0009});
    send_access('{CMD_READ, 16'h0000, 16'h000A});
    settle();

    // Zero ways acts as one way
    set_register(CFG_WAYS_IN_USE, 5'd0);
    send_access('{CMD_READ, 16'h0010, 16'h000B});
    send_access('{CMD_READ, 16'h0010, 16'h000C});
    send_access('{CMD_READ, 16'h0030, 16'h000D});
    settle();

    // Too many ways, too many sets, largest block size
    set_register(CFG_WAYS_IN_USE, 5'd31);
    set_register(CFG_ROW_COUNT_LOG2, 5'd15);
    set_register(CFG_BLOCK_SIZE_LOG2, 5'd7);
    send_access('{CMD_READ,  16'hFFFF, 16'h000E});
    send_access('{CMD_READ,  16'hFF80, 16'h000F});
    send_access('{CMD_WRITE, 16'h0000, 16'h0010});
    settle();

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin ways_v = 5'd4;  rows_v = 5'd2;  blk_v = 5'd2; end
        1: begin ways_v = 5'd16; rows_v = 5'd8;  blk_v = 5'd6; end
        2: begin ways_v = 5'd0;  rows_v = 5'd0;  blk_v = 5'd0; end
        3: begin ways_v = 5'd31; rows_v = 5'd15; blk_v = 5'd7; end
        4: begin ways_v = 5'd1;  rows_v = 5'd4;  blk_v = 5'd0; end
        5: begin ways_v = 5'd17; rows_v = 5'd9;  blk_v = 5'd3; end
        default: begin
          ways_v = 5'($urandom_range(0, 31));
          rows_v = 5'($urandom_range(0, 15));
          blk_v  = 5'($urandom_range(0, 7));
        end
      endcase
      write_mask = (phase < 6) ? 3'b111 : 3'($urandom_range(0, 7));
      if (write_mask[0]) set_register(CFG_WAYS_IN_USE, ways_v);
      if ($urandom_range(0, 2) == 0) set_register(CFG_UNUSED_IDX, 5'($urandom));
      if (write_mask[1]) set_register(CFG_ROW_COUNT_LOG2, rows_v);
      if (write_mask[2]) set_register(CFG_BLOCK_SIZE_LOG2, blk_v);
      tag_base = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 65535);
      no_gaps = 1'b0;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 30 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        hold_off(no_gaps ? 0 : pick_gap());
        send_access('{command: 1'($urandom_range(0, 1)),
                      address: pick_address(tags.ways_eff(), tags.rows_eff(),
                                            32'(tags.block_cfg), tag_base),
                      pc_tag:  16'($urandom)});
      end
      settle();
    end

    tags.close_out();
    if (tags.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
